@@ hdl/obbp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obbp_pkg
// Shared types, widths, codes and corner tables for the oriented box
// projection and contact configuration block.
// ----------------------------------------------------------------------------
package obbp_pkg;

   localparam int COMP_WIDTH  = 20;
   localparam int VEC_WIDTH   = 3 * COMP_WIDTH;
   localparam int PROD_WIDTH  = 2 * COMP_WIDTH;
   localparam int DOT_WIDTH   = PROD_WIDTH + 2;
   localparam int ABS_WIDTH   = PROD_WIDTH;
   localparam int RPROD_WIDTH = ABS_WIDTH + 1 + COMP_WIDTH;
   localparam int FRAC_SHIFT  = 12;
   localparam int TERM_WIDTH  = 48;
   localparam int RAD_WIDTH   = TERM_WIDTH + 2;
   localparam int SUM_WIDTH   = RAD_WIDTH + 1;
   localparam int BOUND_WIDTH = 48;
   localparam int THR_WIDTH   = 25;

   localparam logic [THR_WIDTH-1:0] THR_RESET = 25'd17;
   localparam logic [2:0]           CORNER_MAX = 3'd7;

   localparam logic [1:0] KIND_POINT   = 2'd0;
   localparam logic [1:0] KIND_SEGMENT = 2'd1;
   localparam logic [1:0] KIND_FACE    = 2'd2;

   typedef struct packed {
      logic [VEC_WIDTH-1:0] direction;
      logic [VEC_WIDTH-1:0] box_axis_u;
      logic [VEC_WIDTH-1:0] box_axis_v;
      logic [VEC_WIDTH-1:0] box_axis_w;
      logic [VEC_WIDTH-1:0] half_sizes;
      logic [VEC_WIDTH-1:0] box_center;
   } req_type;

   typedef struct packed {
      logic [1:0]                     contact_kind;
      logic [2:0]                     corner_0;
      logic [2:0]                     corner_1;
      logic [2:0]                     corner_2;
      logic [2:0]                     corner_3;
      logic [2:0]                     corner_4;
      logic [2:0]                     corner_5;
      logic [2:0]                     corner_6;
      logic [2:0]                     corner_7;
      logic signed [BOUND_WIDTH-1:0]  interval_low;
      logic signed [BOUND_WIDTH-1:0]  interval_high;
   } rsp_type;

   typedef struct packed {
      logic [1:0]      kind;
      logic [7:0][2:0] corner;
      logic [2:0]      used;
   } cls_type;

   // [face normal axis][normal not positive][slot]
   localparam logic [2:0] FACE_TAB [0:2][0:1][0:7] = '{
      '{ '{3'd0, 3'd2, 3'd6, 3'd4, 3'd5, 3'd7, 3'd3, 3'd1},
         '{3'd5, 3'd7, 3'd3, 3'd1, 3'd0, 3'd2, 3'd6, 3'd4} },
      '{ '{3'd4, 3'd5, 3'd1, 3'd0, 3'd2, 3'd3, 3'd7, 3'd6},
         '{3'd2, 3'd3, 3'd7, 3'd6, 3'd4, 3'd5, 3'd1, 3'd0} },
      '{ '{3'd0, 3'd1, 3'd3, 3'd2, 3'd6, 3'd7, 3'd5, 3'd4},
         '{3'd6, 3'd7, 3'd5, 3'd4, 3'd0, 3'd1, 3'd3, 3'd2} }
   };

   // [perpendicular axis][first other not positive][second other not positive]
   // holds min0, min1, max0, max1
   localparam logic [2:0] SEG_TAB [0:2][0:1][0:1][0:3] = '{
      '{ '{ '{3'd0, 3'd1, 3'd6, 3'd7}, '{3'd4, 3'd5, 3'd2, 3'd3} },
         '{ '{3'd2, 3'd3, 3'd4, 3'd5}, '{3'd6, 3'd7, 3'd0, 3'd1} } },
      '{ '{ '{3'd0, 3'd2, 3'd5, 3'd7}, '{3'd4, 3'd6, 3'd1, 3'd3} },
         '{ '{3'd1, 3'd3, 3'd4, 3'd6}, '{3'd5, 3'd7, 3'd0, 3'd2} } },
      '{ '{ '{3'd0, 3'd4, 3'd3, 3'd7}, '{3'd2, 3'd6, 3'd1, 3'd5} },
         '{ '{3'd1, 3'd5, 3'd2, 3'd6}, '{3'd3, 3'd7, 3'd0, 3'd4} } }
   };

   function automatic logic signed [COMP_WIDTH-1:0] vec_comp(
      input logic [VEC_WIDTH-1:0] v,
      input int unsigned          k
   );
      vec_comp = $signed(v[k*COMP_WIDTH +: COMP_WIDTH]);
   endfunction

endpackage

@@ hdl/obb_axis_projection_config.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_axis_projection_config
// Projects an oriented box onto a separating axis, classifies the extreme
// features and gives their corner indices and the projected interval.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock while the result side keeps rsp_ready
// high. The datapath has five register stages: the twelve component
// multipliers, the dot product adders, the radius multipliers beside the
// epsilon compare and corner lookup, the radius sum, and the interval add
// with saturation. Each stage stalls only when the stage behind it is full
// and stalled, so empty stages close up. The epsilon register may be
// written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module obb_axis_projection_config
   import obbp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [THR_WIDTH-1:0] csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data
);

   logic [THR_WIDTH-1:0] thr_ff, thr_in;

   logic s1_valid_ff, s1_valid_in, s1_ready;
   logic s2_valid_ff, s2_valid_in, s2_ready;
   logic s3_valid_ff, s3_valid_in, s3_ready;
   logic s4_valid_ff, s4_valid_in, s4_ready;
   logic s5_valid_ff, s5_valid_in, s5_ready;

   logic [VEC_WIDTH-1:0] vec_sel [4];

   logic signed [PROD_WIDTH-1:0] s1_prod_ff [4][3];
   logic signed [PROD_WIDTH-1:0] s1_prod_in [4][3];
   logic [VEC_WIDTH-1:0]         s1_half_ff, s1_half_in;

   logic signed [DOT_WIDTH-1:0]  dot [4];
   logic [ABS_WIDTH-1:0]         s2_abs_ff [3];
   logic [ABS_WIDTH-1:0]         s2_abs_in [3];
   logic [2:0]                   s2_pos_ff, s2_pos_in;
   logic signed [DOT_WIDTH-1:0]  s2_org_ff, s2_org_in;
   logic [VEC_WIDTH-1:0]         s2_half_ff, s2_half_in;

   logic signed [RPROD_WIDTH-1:0] rad_prod [3];
   logic [2:0]                    zero_flags;
   cls_type                       cls;
   logic signed [TERM_WIDTH-1:0]  s3_term_ff [3];
   logic signed [TERM_WIDTH-1:0]  s3_term_in [3];
   cls_type                       s3_cls_ff, s3_cls_in;
   logic signed [DOT_WIDTH-1:0]   s3_org_ff, s3_org_in;

   logic signed [RAD_WIDTH-1:0]   s4_rad_ff, s4_rad_in;
   logic [1:0]                    s4_kind_ff, s4_kind_in;
   logic [7:0][2:0]               s4_corner_ff, s4_corner_in;
   logic signed [DOT_WIDTH-1:0]   s4_org_ff, s4_org_in;

   logic signed [SUM_WIDTH-1:0]   low_sum, high_sum;
   rsp_type                       s5_rsp_ff, s5_rsp_in;

   function automatic logic signed [BOUND_WIDTH-1:0] sat_bound(
      input logic signed [SUM_WIDTH-1:0] x
   );
      logic [SUM_WIDTH-BOUND_WIDTH:0] top;
      top = x[SUM_WIDTH-1:BOUND_WIDTH-1];
      if (!x[SUM_WIDTH-1] && (|top)) begin
         sat_bound = {1'b0, {(BOUND_WIDTH-1){1'b1}}};
      end else if (x[SUM_WIDTH-1] && !(&top)) begin
         sat_bound = {1'b1, {(BOUND_WIDTH-1){1'b0}}};
      end else begin
         sat_bound = x[BOUND_WIDTH-1:0];
      end
   endfunction

   // stage handshake
   assign s5_ready  = !s5_valid_ff || rsp_ready;
   assign s4_ready  = !s4_valid_ff || s5_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   assign thr_in      = csr_wr_en ? csr_wr_data : thr_ff;
   assign s1_valid_in = s1_ready ? req_valid   : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in = s4_ready ? s3_valid_ff : s4_valid_ff;
   assign s5_valid_in = s5_ready ? s4_valid_ff : s5_valid_ff;

   // stage 1: component products
   assign vec_sel[0] = req_data.box_axis_u;
   assign vec_sel[1] = req_data.box_axis_v;
   assign vec_sel[2] = req_data.box_axis_w;
   assign vec_sel[3] = req_data.box_center;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         for (int k = 0; k < 3; k++) begin
            s1_prod_in[j][k] = vec_comp(req_data.direction, k) * vec_comp(vec_sel[j], k);
         end
      end
      s1_half_in = req_data.half_sizes;
   end

   // stage 2: dot products, magnitude and sign
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         dot[j] = DOT_WIDTH'(s1_prod_ff[j][0]) + DOT_WIDTH'(s1_prod_ff[j][1]) +
                  DOT_WIDTH'(s1_prod_ff[j][2]);
      end
      for (int k = 0; k < 3; k++) begin
         s2_abs_in[k] = dot[k][DOT_WIDTH-1] ? ABS_WIDTH'(-dot[k]) : ABS_WIDTH'(dot[k]);
         s2_pos_in[k] = !dot[k][DOT_WIDTH-1] && (|dot[k]);
      end
      s2_org_in  = dot[3];
      s2_half_in = s1_half_ff;
   end

   // stage 3: radius terms, epsilon compare and feature lookup
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rad_prod[k]   = $signed({1'b0, s2_abs_ff[k]}) * vec_comp(s2_half_ff, k);
         s3_term_in[k] = rad_prod[k][FRAC_SHIFT +: TERM_WIDTH];
         zero_flags[k] = s2_abs_ff[k] < {{(ABS_WIDTH-THR_WIDTH){1'b0}}, thr_ff};
      end
      s3_cls_in = cls;
      s3_org_in = s2_org_ff;
   end

   obbp_classify u_classify (
      .zero_flags (zero_flags),
      .pos_flags  (s2_pos_ff),
      .cls        (cls)
   );

   // stage 4: radius sum over the axes that reach the extreme feature
   always_comb begin
      s4_rad_in = '0;
      for (int k = 0; k < 3; k++) begin
         if (s3_cls_ff.used[k]) begin
            s4_rad_in = s4_rad_in + RAD_WIDTH'(s3_term_ff[k]);
         end
      end
      s4_kind_in   = s3_cls_ff.kind;
      s4_corner_in = s3_cls_ff.corner;
      s4_org_in    = s3_org_ff;
   end

   // stage 5: interval bounds
   always_comb begin
      low_sum  = SUM_WIDTH'(s4_org_ff) - SUM_WIDTH'(s4_rad_ff);
      high_sum = SUM_WIDTH'(s4_org_ff) + SUM_WIDTH'(s4_rad_ff);
      s5_rsp_in.contact_kind  = s4_kind_ff;
      s5_rsp_in.corner_0      = s4_corner_ff[0];
      s5_rsp_in.corner_1      = s4_corner_ff[1];
      s5_rsp_in.corner_2      = s4_corner_ff[2];
      s5_rsp_in.corner_3      = s4_corner_ff[3];
      s5_rsp_in.corner_4      = s4_corner_ff[4];
      s5_rsp_in.corner_5      = s4_corner_ff[5];
      s5_rsp_in.corner_6      = s4_corner_ff[6];
      s5_rsp_in.corner_7      = s4_corner_ff[7];
      s5_rsp_in.interval_low  = sat_bound(low_sum);
      s5_rsp_in.interval_high = sat_bound(high_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= THR_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         thr_ff      <= thr_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_prod_ff <= s1_prod_in;
         s1_half_ff <= s1_half_in;
      end
      if (s2_ready) begin
         s2_abs_ff  <= s2_abs_in;
         s2_pos_ff  <= s2_pos_in;
         s2_org_ff  <= s2_org_in;
         s2_half_ff <= s2_half_in;
      end
      if (s3_ready) begin
         s3_term_ff <= s3_term_in;
         s3_cls_ff  <= s3_cls_in;
         s3_org_ff  <= s3_org_in;
      end
      if (s4_ready) begin
         s4_rad_ff    <= s4_rad_in;
         s4_kind_ff   <= s4_kind_in;
         s4_corner_ff <= s4_corner_in;
         s4_org_ff    <= s4_org_in;
      end
      if (s5_ready) begin
         s5_rsp_ff <= s5_rsp_in;
      end
   end

   assign rsp_valid = s5_valid_ff;
   assign rsp_data  = s5_rsp_ff;

   a_point_corners : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.contact_kind == KIND_POINT) |->
         (rsp_data.corner_7 == CORNER_MAX - rsp_data.corner_0) &&
         (rsp_data.corner_1 == 3'd0) && (rsp_data.corner_6 == 3'd0))
      else $error("point contact corners inconsistent");

   a_segment_slots : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.contact_kind == KIND_SEGMENT) |->
         (rsp_data.corner_2 == 3'd0) && (rsp_data.corner_3 == 3'd0) &&
         (rsp_data.corner_4 == 3'd0) && (rsp_data.corner_5 == 3'd0))
      else $error("segment contact uses face slots");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !s4_ready |=> s3_valid_ff && $stable(s3_org_ff))
      else $error("stalled stage lost its transaction");

   a_full_blocks : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && s5_valid_ff &&
         !rsp_ready |-> !req_ready)
      else $error("full pipeline accepted a transaction");

endmodule

@@ hdl/obbp_classify.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obbp_classify
// Classifies the extreme features as point, edge or face from the
// perpendicular flags and projection signs, and looks up the corner order.
// ----------------------------------------------------------------------------
module obbp_classify
   import obbp_pkg::*;
(
   input  logic [2:0] zero_flags,
   input  logic [2:0] pos_flags,
   output cls_type    cls
);

   logic       two_zero;
   logic [1:0] face_axis;
   logic [1:0] seg_axis;
   logic [1:0] first_axis;
   logic [1:0] second_axis;
   logic [2:0] point_corner;

   assign two_zero = (zero_flags[0] & zero_flags[1]) | (zero_flags[0] & zero_flags[2]) |
                     (zero_flags[1] & zero_flags[2]);
   assign face_axis = (zero_flags[0] & zero_flags[1]) ? 2'd2 : (zero_flags[0] ? 2'd1 : 2'd0);

   assign seg_axis    = zero_flags[0] ? 2'd0 : (zero_flags[1] ? 2'd1 : 2'd2);
   assign first_axis  = (seg_axis == 2'd0) ? 2'd1 : 2'd0;
   assign second_axis = (seg_axis == 2'd2) ? 2'd1 : 2'd2;
   assign point_corner = ~pos_flags;

   always_comb begin
      cls = '0;
      if (two_zero) begin
         cls.kind = KIND_FACE;
         cls.used[face_axis] = 1'b1;
         for (int i = 0; i < 8; i++) begin
            cls.corner[i] = FACE_TAB[face_axis][!pos_flags[face_axis]][i];
         end
      end else if (|zero_flags) begin
         cls.kind = KIND_SEGMENT;
         cls.used[first_axis]  = 1'b1;
         cls.used[second_axis] = 1'b1;
         cls.corner[0] = SEG_TAB[seg_axis][!pos_flags[first_axis]][!pos_flags[second_axis]][0];
         cls.corner[1] = SEG_TAB[seg_axis][!pos_flags[first_axis]][!pos_flags[second_axis]][1];
         cls.corner[6] = SEG_TAB[seg_axis][!pos_flags[first_axis]][!pos_flags[second_axis]][2];
         cls.corner[7] = SEG_TAB[seg_axis][!pos_flags[first_axis]][!pos_flags[second_axis]][3];
      end else begin
         cls.kind = KIND_POINT;
         cls.used = 3'b111;
         cls.corner[0] = point_corner;
         cls.corner[7] = CORNER_MAX - point_corner;
      end
   end

endmodule
